// ===== hw/rtl/pct_pkg.sv =====
// shared constants and codes of the packed component table
`default_nettype none

package pct_pkg;

  localparam int CAPACITY     = 256;
  localparam int ENTITY_RANGE = 1024;

  localparam int OP_W   = 2;
  localparam int ID_W   = 10;
  localparam int VAL_W  = 32;
  localparam int ST_W   = 3;
  localparam int CNT_W  = 9;
  localparam int SLOT_W = $clog2(CAPACITY);

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [ID_W-1:0]   id_t;
  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [ST_W-1:0]   status_t;
  typedef logic [CNT_W-1:0]  count_t;
  typedef logic [SLOT_W-1:0] slot_t;

  localparam op_t OP_ADD    = 2'd0;
  localparam op_t OP_REMOVE = 2'd1;
  localparam op_t OP_GET    = 2'd2;

  localparam status_t ST_UPDATED   = 3'd0;
  localparam status_t ST_APPENDED  = 3'd1;
  localparam status_t ST_DONE      = 3'd2;
  localparam status_t ST_NOT_FOUND = 3'd3;
  localparam status_t ST_FULL      = 3'd4;

endpackage

`default_nettype wire

// ===== hw/rtl/pct_if.sv =====
// request and response stream interfaces of the packed component table
`default_nettype none

interface pct_req_if
  import pct_pkg::*;
;
  logic valid;
  logic ready;
  op_t  operation;
  id_t  entity_id;
  val_t component_value;

  modport source (output valid, output operation, output entity_id,
                  output component_value, input ready);
  modport sink   (input valid, input operation, input entity_id,
                  input component_value, output ready);
endinterface

interface pct_rsp_if
  import pct_pkg::*;
;
  logic    valid;
  logic    ready;
  status_t status;
  val_t    read_value;
  count_t  entry_count;

  modport source (output valid, output status, output read_value,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input read_value,
                  input entry_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/packed_component_table_unit.sv =====
// packed component table: entity id to component value store kept densely packed
//
//   channel  dir  beat contents                               handshake
//   in_chan  in   operation, entity_id, component_value       valid / ready
//   out_chan out  status, read_value, entry_count             valid / ready
//
// one request at a time: add, get and remove of the last entry pass through S_OWN, S_CHK
// and S_OUT, loading the result in S_OUT and taking the next request after that; a remove that
// moves the last entry passes through S_MOVE between S_CHK and S_OUT
// these steps follow the chained registered ram reads: id map, then owner/value, then compare
// reset clears the state, the entry count and the output valid; the three rams need no clearing pass
// the result sits in an output register; in_chan is ready again once it is loaded
// a stalled out_chan holds the result and keeps the next request waiting in S_OUT
`default_nettype none

module packed_component_table_unit
  import pct_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  pct_req_if.sink   in_chan,
  pct_rsp_if.source out_chan
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_OWN  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_MOVE = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_r, state_nxt;
  op_t        op_r, op_nxt;
  id_t        id_r, id_nxt;
  val_t       val_r, val_nxt;
  slot_t      slot_r, slot_nxt;
  count_t     count_r, count_nxt;
  status_t    res_status_r, res_status_nxt;
  val_t       res_value_r, res_value_nxt;
  logic       out_valid_r, out_valid_nxt;
  status_t    out_status_r, out_status_nxt;
  val_t       out_value_r, out_value_nxt;
  count_t     out_count_r, out_count_nxt;

  logic   map_we, map_re;
  id_t    map_waddr, map_raddr;
  slot_t  map_wdata, map_rdata;
  logic   own_we, own_re;
  slot_t  own_waddr, own_raddr;
  id_t    own_wdata, own_rdata;
  logic   val_we, val_re;
  slot_t  val_waddr, val_raddr;
  val_t   val_wdata, val_rdata;

  logic   accept;
  logic   present;
  logic   id_ok;
  count_t last;

  assign accept = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.read_value  = out_value_r;
  assign out_chan.entry_count = out_count_r;

  assign last    = count_r - count_t'(1);
  assign id_ok   = {1'b0, id_r} < (ID_W + 1)'(ENTITY_RANGE);
  // mapped slot must be live and owned by the same entity
  assign present = id_ok && ({1'b0, slot_r} < count_r) && (own_rdata == id_r);

  pct_ram #(.WIDTH(SLOT_W), .DEPTH(ENTITY_RANGE)) u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .re(map_re), .raddr(map_raddr), .rdata(map_rdata)
  );

  pct_ram #(.WIDTH(ID_W), .DEPTH(CAPACITY)) u_owners (
    .clk(clk), .we(own_we), .waddr(own_waddr), .wdata(own_wdata),
    .re(own_re), .raddr(own_raddr), .rdata(own_rdata)
  );

  pct_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_values (
    .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
    .re(val_re), .raddr(val_raddr), .rdata(val_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    id_nxt         = id_r;
    val_nxt        = val_r;
    slot_nxt       = slot_r;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_count_nxt  = out_count_r;

    map_re    = 1'b0;
    map_raddr = in_chan.entity_id;
    map_we    = 1'b0;
    map_waddr = id_r;
    map_wdata = count_r[SLOT_W-1:0];
    own_re    = 1'b0;
    own_raddr = map_rdata;
    own_we    = 1'b0;
    own_waddr = count_r[SLOT_W-1:0];
    own_wdata = id_r;
    val_re    = 1'b0;
    val_raddr = map_rdata;
    val_we    = 1'b0;
    val_waddr = count_r[SLOT_W-1:0];
    val_wdata = val_r;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt    = in_chan.operation;
          id_nxt    = in_chan.entity_id;
          val_nxt   = in_chan.component_value;
          map_re    = 1'b1;
          state_nxt = S_OWN;
        end
      end
      S_OWN: begin
        own_re    = 1'b1;
        val_re    = 1'b1;
        slot_nxt  = map_rdata;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        res_status_nxt = ST_NOT_FOUND;
        res_value_nxt  = '0;
        state_nxt      = S_OUT;
        if (id_ok) begin
          unique case (op_r)
            OP_ADD: begin
              if (present) begin
                val_we         = 1'b1;
                val_waddr      = slot_r;
                res_status_nxt = ST_UPDATED;
              end else if (count_r < count_t'(CAPACITY)) begin
                // append at the end and point the map at the new slot
                val_we         = 1'b1;
                own_we         = 1'b1;
                map_we         = 1'b1;
                count_nxt      = count_r + count_t'(1);
                res_status_nxt = ST_APPENDED;
              end else begin
                res_status_nxt = ST_FULL;
              end
            end
            OP_REMOVE: begin
              if (present) begin
                res_status_nxt = ST_DONE;
                if ({1'b0, slot_r} == last) begin
                  count_nxt = last;
                end else begin
                  own_re    = 1'b1;
                  val_re    = 1'b1;
                  own_raddr = last[SLOT_W-1:0];
                  val_raddr = last[SLOT_W-1:0];
                  state_nxt = S_MOVE;
                end
              end
            end
            OP_GET: begin
              if (present) begin
                res_status_nxt = ST_DONE;
                res_value_nxt  = val_rdata;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_MOVE: begin
        // last entry fills the freed slot
        val_we    = 1'b1;
        val_waddr = slot_r;
        val_wdata = val_rdata;
        own_we    = 1'b1;
        own_waddr = slot_r;
        own_wdata = own_rdata;
        map_we    = 1'b1;
        map_waddr = own_rdata;
        map_wdata = slot_r;
        count_nxt = last;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          out_count_nxt  = count_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    id_r         <= id_nxt;
    val_r        <= val_nxt;
    slot_r       <= slot_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= count_t'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_OWN)
    else $error("accepted request did not start the lookup");

  a_move_on_remove: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MOVE |-> op_r == OP_REMOVE)
    else $error("entry move outside a remove");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(count_r) |-> $past(state_r) == S_CHK || $past(state_r) == S_MOVE)
    else $error("entry count changed outside request completion");

  a_count_delta: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(count_r) |-> count_r == $past(count_r) + count_t'(1)
                       || count_r == $past(count_r) - count_t'(1))
    else $error("entry count moved by more than one");

endmodule

`default_nettype wire

// ===== hw/rtl/pct_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none

module pct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
